FILE: design/dq_pkg.sv
// Shared constants, types and index helpers for the double-ended queue.
package dq_pkg;

   localparam int DEPTH        = 16;
   localparam int DATA_W       = 32;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int OP_W         = 3;
   localparam int STAT_W       = 2;
   localparam int REQ_TDATA_W  = ((DATA_W + 7) / 8) * 8;
   localparam int RSP_W        = DATA_W + 1 + STAT_W + CNT_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_REAR  = 3'd5,
      OP_SEARCH     = 3'd6
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == IDX_W'(DEPTH - 1)) r = '0;
      else                        r = i + IDX_W'(1);
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == '0) r = IDX_W'(DEPTH - 1);
      else         r = i - IDX_W'(1);
      return r;
   endfunction

endpackage

FILE: design/dq_ram.sv
// Entry store: one write port, one read port, registered read data.
module dq_ram
   import dq_pkg::*;
(
   input  logic              clock,
   input  ram_wr_type        wr,
   input  ram_rd_type        rd,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

FILE: design/double_ended_queue.sv
// Double-ended queue of signed words held in a ring store, top level.
//
// Requests arrive on the req_ stream: req_tuser carries the operation, req_tdata the
// value to push or the key to search for. Every request yields exactly one transaction
// on the rsp_ stream with the popped/peeked value, found flag, status, count and empty.
// Path from request acceptance to rsp_tvalid:
//   push, unused code, pop/peek on empty, push on full, search on empty: straight
//   into the response register; pop and peek: entry store read, ST_READ, response.
//   search: the store is walked one entry per cycle from the front in ST_SRCH and
//   the walk stops at the first match or after the last held entry.
// Throughput: one push per cycle while responses are taken; a pop or peek blocks
// new requests until its read of the single read port of the store is answered.
// The response register frees the request side: a new request is taken in the
// cycle the pending response is taken. While rsp_tready stays low, a held response
// blocks further requests and its payload holds.
// Reset (synchronous, active high) empties the queue: pointers and count clear,
// no response is pending. Store contents are not cleared; only held entries are read.
module double_ended_queue
   import dq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [31:0] data_value
   input  logic [OP_W-1:0]        req_tuser,  // [2:0] op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // result_value, found, status, count,
                                              // queue_empty, zero fill
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SRCH = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  rear_ff, rear_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]  srch_idx_ff, srch_idx_in;
   logic [CNT_W-1:0]  srch_left_ff, srch_left_in;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_found_ff;
   status_type        rsp_status_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   ram_wr_type        ram_wr;
   ram_rd_type        ram_rd;
   logic [DATA_W-1:0] ram_rd_data;

   logic              req_accept;
   op_type            req_op;
   logic              q_full;
   logic              q_empty;
   logic              res_fire;
   logic [DATA_W-1:0] res_value;
   logic              res_found;
   status_type        res_status;
   logic [IDX_W-1:0]  new_idx;

   dq_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign q_full     = (count_ff == CNT_W'(DEPTH));
   assign q_empty    = (count_ff == '0);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      srch_idx_in  = srch_idx_ff;
      srch_left_in = srch_left_ff;
      ram_wr       = '0;
      ram_rd       = '0;
      res_fire     = 1'b0;
      res_value    = '0;
      res_found    = 1'b0;
      res_status   = STAT_OK;
      new_idx      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_PUSH_FRONT: begin
                     res_fire = 1'b1;
                     if (q_full) begin
                        res_status = STAT_FULL;
                     end else begin
                        new_idx     = idx_dec(front_ff);
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = new_idx;
                        ram_wr.data = req_tdata[DATA_W-1:0];
                        front_in    = new_idx;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_REAR: begin
                     res_fire = 1'b1;
                     if (q_full) begin
                        res_status = STAT_FULL;
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = rear_ff;
                        ram_wr.data = req_tdata[DATA_W-1:0];
                        rear_in     = idx_inc(rear_ff);
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (q_empty) begin
                        res_fire   = 1'b1;
                        res_status = STAT_EMPTY;
                     end else begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = front_ff;
                        front_in    = idx_inc(front_ff);
                        count_in    = count_ff - CNT_W'(1);
                        state_in    = ST_READ;
                     end
                  end
                  OP_POP_REAR: begin
                     if (q_empty) begin
                        res_fire   = 1'b1;
                        res_status = STAT_EMPTY;
                     end else begin
                        new_idx     = idx_dec(rear_ff);
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = new_idx;
                        rear_in     = new_idx;
                        count_in    = count_ff - CNT_W'(1);
                        state_in    = ST_READ;
                     end
                  end
                  OP_PEEK_FRONT: begin
                     if (q_empty) begin
                        res_fire   = 1'b1;
                        res_status = STAT_EMPTY;
                     end else begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = front_ff;
                        state_in    = ST_READ;
                     end
                  end
                  OP_PEEK_REAR: begin
                     if (q_empty) begin
                        res_fire   = 1'b1;
                        res_status = STAT_EMPTY;
                     end else begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = idx_dec(rear_ff);
                        state_in    = ST_READ;
                     end
                  end
                  OP_SEARCH: begin
                     if (q_empty) begin
                        res_fire = 1'b1;
                     end else begin
                        ram_rd.en    = 1'b1;
                        ram_rd.addr  = front_ff;
                        srch_idx_in  = idx_inc(front_ff);
                        srch_left_in = count_ff;
                        key_in       = req_tdata[DATA_W-1:0];
                        state_in     = ST_SRCH;
                     end
                  end
                  default: begin
                     res_fire = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_fire  = 1'b1;
            res_value = ram_rd_data;
            state_in  = ST_IDLE;
         end
         ST_SRCH: begin
            // compare the entry read last cycle; on a miss with entries left, fetch the next one
            if (ram_rd_data == key_ff) begin
               res_fire  = 1'b1;
               res_found = 1'b1;
               state_in  = ST_IDLE;
            end else if (srch_left_ff == CNT_W'(1)) begin
               res_fire = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ram_rd.en    = 1'b1;
               ram_rd.addr  = srch_idx_ff;
               srch_idx_in  = idx_inc(srch_idx_ff);
               srch_left_in = srch_left_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         rear_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
         if (res_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      srch_idx_ff  <= srch_idx_in;
      srch_left_ff <= srch_left_in;
      if (res_fire) begin
         rsp_value_ff  <= res_value;
         rsp_found_ff  <= res_found;
         rsp_status_ff <= res_status;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_W){1'b0}},
                        (rsp_count_ff == '0),
                        rsp_count_ff,
                        rsp_status_ff,
                        rsp_found_ff,
                        rsp_value_ff};

endmodule
